// File: hw/rtl/smsahe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants, character tables and microprogram of the SMS address hex encoder.
package smsahe_pkg;

   typedef logic [3:0] pc_type;

   typedef enum logic [2:0] {
      SRC_LEN_HI,
      SRC_LEN_LO,
      SRC_TOA_HI,
      SRC_TOA_LO,
      SRC_MEM,
      SRC_PAD,
      SRC_ERR
   } src_type;

   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NOT_LAST_IN,
      CND_NOT_OVF,
      CND_REM_ZERO,
      CND_REM_ONE,
      CND_REM_TWO
   } cond_type;

   typedef struct packed {
      logic     take;
      logic     emit;
      src_type  src;
      logic     rd;
      logic     rd_hi;
      logic     adv;
      logic     start;
      cond_type jcond;
      cond_type econd;
      pc_type   target;
   } ctrl_type;

   typedef struct packed {
      logic last_in;
      logic ovf;
      logic rem_zero;
      logic rem_one;
      logic rem_two;
      logic out_free;
   } flags_type;

   typedef struct packed {
      ctrl_type ctrl;
      logic     go;
      logic     end_run;
   } seq_stat_type;

   localparam pc_type STEP_IDLE    = 4'd0;
   localparam pc_type STEP_CHECK   = 4'd1;
   localparam pc_type STEP_ERR     = 4'd2;
   localparam pc_type STEP_LEN_HI  = 4'd3;
   localparam pc_type STEP_LEN_LO  = 4'd4;
   localparam pc_type STEP_TOA_HI  = 4'd5;
   localparam pc_type STEP_TOA_LO  = 4'd6;
   localparam pc_type STEP_PAIR    = 4'd7;
   localparam pc_type STEP_EMIT_HI = 4'd8;
   localparam pc_type STEP_EMIT_LO = 4'd9;
   localparam pc_type STEP_LOOP    = 4'd10;
   localparam pc_type STEP_PAD     = 4'd11;
   localparam pc_type STEP_TAIL    = 4'd12;

   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] ASCII_NINE   = 8'h39;
   localparam logic [7:0] ASCII_STAR   = 8'h2a;
   localparam logic [7:0] ASCII_HASH   = 8'h23;
   localparam logic [7:0] ASCII_A      = 8'h61;
   localparam logic [7:0] ASCII_B      = 8'h62;
   localparam logic [7:0] ASCII_C      = 8'h63;
   localparam logic [7:0] ASCII_A_OFS  = 8'h57;

   localparam logic [3:0] CODE_STAR    = 4'd10;
   localparam logic [3:0] CODE_HASH    = 4'd11;
   localparam logic [3:0] CODE_A       = 4'd12;
   localparam logic [3:0] CODE_B       = 4'd13;
   localparam logic [3:0] CODE_C       = 4'd14;
   localparam logic [3:0] CODE_NONE    = 4'd15;

   localparam logic [2:0] TON_MAX      = 3'd4;
   localparam logic [3:0] NPI_ISDN     = 4'd1;
   localparam logic [3:0] NPI_DATA     = 4'd3;
   localparam logic [3:0] NPI_TELEX    = 4'd4;
   localparam logic [3:0] NPI_NATIONAL = 4'd8;
   localparam logic [3:0] NPI_PRIVATE  = 4'd9;

   localparam ctrl_type CTRL_NOP = '{
      take: 1'b0, emit: 1'b0, src: SRC_PAD, rd: 1'b0, rd_hi: 1'b0, adv: 1'b0,
      start: 1'b0, jcond: CND_NEVER, econd: CND_NEVER, target: STEP_IDLE
   };

   function automatic logic [3:0] char_code(input logic [7:0] c);
      logic [3:0] code;
      code = CODE_NONE;
      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
         code = c[3:0];
      end else begin
         unique case (c)
            ASCII_STAR: code = CODE_STAR;
            ASCII_HASH: code = CODE_HASH;
            ASCII_A:    code = CODE_A;
            ASCII_B:    code = CODE_B;
            ASCII_C:    code = CODE_C;
            default:    code = CODE_NONE;
         endcase
      end
      return code;
   endfunction

   function automatic logic [7:0] hex_ascii(input logic [3:0] n);
      return (n < 4'd10) ? ({4'h0, n} + ASCII_ZERO) : ({4'h0, n} + ASCII_A_OFS);
   endfunction

   function automatic logic [7:0] toa_octet(input logic [2:0] ton, input logic [3:0] npi);
      logic [2:0] t;
      logic [3:0] p;
      t = (ton <= TON_MAX) ? ton : 3'd0;
      case (npi) inside
         NPI_ISDN, NPI_DATA, NPI_TELEX, NPI_NATIONAL, NPI_PRIVATE: p = npi;
         default: p = 4'd0;
      endcase
      return {1'b1, t, p};
   endfunction

   function automatic logic cond_true(input cond_type c, input flags_type f);
      logic r;
      unique case (c)
         CND_NEVER:       r = 1'b0;
         CND_ALWAYS:      r = 1'b1;
         CND_NOT_LAST_IN: r = !f.last_in;
         CND_NOT_OVF:     r = !f.ovf;
         CND_REM_ZERO:    r = f.rem_zero;
         CND_REM_ONE:     r = f.rem_one;
         CND_REM_TWO:     r = f.rem_two;
         default:         r = 1'b0;
      endcase
      return r;
   endfunction

   // The microprogram: one control word per step.
   function automatic ctrl_type micro_word(input pc_type pc);
      ctrl_type w;
      w = CTRL_NOP;
      unique case (pc)
         STEP_IDLE: begin
            w.take = 1'b1; w.jcond = CND_NOT_LAST_IN; w.target = STEP_IDLE;
         end
         STEP_CHECK: begin
            w.start = 1'b1; w.jcond = CND_NOT_OVF; w.target = STEP_LEN_HI;
         end
         STEP_ERR: begin
            w.emit = 1'b1; w.src = SRC_ERR;
            w.jcond = CND_ALWAYS; w.econd = CND_ALWAYS; w.target = STEP_IDLE;
         end
         STEP_LEN_HI: begin
            w.emit = 1'b1; w.src = SRC_LEN_HI;
         end
         STEP_LEN_LO: begin
            w.emit = 1'b1; w.src = SRC_LEN_LO;
         end
         STEP_TOA_HI: begin
            w.emit = 1'b1; w.src = SRC_TOA_HI;
         end
         STEP_TOA_LO: begin
            w.emit = 1'b1; w.src = SRC_TOA_LO;
            w.jcond = CND_REM_ZERO; w.econd = CND_REM_ZERO; w.target = STEP_IDLE;
         end
         STEP_PAIR: begin
            w.rd = 1'b1; w.rd_hi = 1'b1; w.jcond = CND_REM_ONE; w.target = STEP_PAD;
         end
         STEP_EMIT_HI: begin
            w.emit = 1'b1; w.src = SRC_MEM; w.rd = 1'b1;
         end
         STEP_EMIT_LO: begin
            w.emit = 1'b1; w.src = SRC_MEM; w.adv = 1'b1;
            w.jcond = CND_REM_TWO; w.econd = CND_REM_TWO; w.target = STEP_IDLE;
         end
         STEP_LOOP: begin
            w.jcond = CND_ALWAYS; w.target = STEP_PAIR;
         end
         STEP_PAD: begin
            w.emit = 1'b1; w.src = SRC_PAD; w.rd = 1'b1;
         end
         STEP_TAIL: begin
            w.emit = 1'b1; w.src = SRC_MEM;
            w.jcond = CND_ALWAYS; w.econd = CND_ALWAYS; w.target = STEP_IDLE;
         end
         default: begin
            w.jcond = CND_ALWAYS; w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/smsahe_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response transactions.
interface smsahe_req_if;
   logic       valid;
   logic       ready;
   logic       has_char;
   logic [7:0] number_char;
   logic       is_last;
   logic [2:0] type_of_number;
   logic [3:0] numbering_plan;

   modport source (
      output valid, has_char, number_char, is_last, type_of_number, numbering_plan,
      input  ready
   );
   modport sink (
      input  valid, has_char, number_char, is_last, type_of_number, numbering_plan,
      output ready
   );
endinterface

interface smsahe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] hex_char;
   logic       overflow;
   logic       end_of_run;

   modport source (
      output valid, hex_char, overflow, end_of_run,
      input  ready
   );
   modport sink (
      input  valid, hex_char, overflow, end_of_run,
      output ready
   );
endinterface

// File: hw/rtl/smsahe_seq.sv
`timescale 1ns / 1ps
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module smsahe_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  smsahe_pkg::flags_type    flags,
   output smsahe_pkg::seq_stat_type stat
);

   smsahe_pkg::pc_type   pc_ff;
   smsahe_pkg::pc_type   pc_in;
   smsahe_pkg::ctrl_type ctrl;
   logic                 go;
   logic                 jump;

   always_comb begin
      ctrl = smsahe_pkg::micro_word(pc_ff);
      go   = !ctrl.emit || flags.out_free;
      jump = smsahe_pkg::cond_true(ctrl.jcond, flags);
      pc_in = pc_ff;
      if (go) begin
         pc_in = jump ? ctrl.target : smsahe_pkg::pc_type'(pc_ff + 1'b1);
      end
      stat.ctrl    = ctrl;
      stat.go      = go;
      stat.end_run = smsahe_pkg::cond_true(ctrl.econd, flags);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= smsahe_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: hw/rtl/sms_address_hex_encoder.sv
`timescale 1ns / 1ps
// Top level of the SMS address hex encoder: digit store, counters and output register.
//
//   Port    Direction  Carries
//   req_if  sink       one raw number character per transaction, with last flag and TON/NPI
//   rsp_if  source     one lowercase hex ASCII character per transaction, or one error
//
// A character is taken in the idle step; the last one starts emission after one check step.
// The four header characters come first, then each digit pair: two digit store reads, two hex
// characters and a loop step; the final pair has no loop step, and an odd tail emits a pad and
// its digit. Requests are refused from the last transaction until the final response is
// registered. A stalled response holds the sequencer in its emitting step. Reset is synchronous.
module sms_address_hex_encoder #(
   parameter int MAX_CHARS = 32
) (
   input  logic        clock,
   input  logic        reset,
   smsahe_req_if.sink   req_if,
   smsahe_rsp_if.source rsp_if
);

   localparam int CW = $clog2(MAX_CHARS + 1);
   localparam int AW = $clog2(MAX_CHARS);

   smsahe_pkg::flags_type    flags;
   smsahe_pkg::seq_stat_type stat;

   logic [3:0]    store_mem [MAX_CHARS];
   logic [3:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;

   logic [CW-1:0] kept_ff, kept_in;
   logic [CW-1:0] raw_ff, raw_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    toa_ff, toa_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    hex_ff, hex_in;
   logic          ovf_ff, ovf_in;
   logic          end_ff, end_in;

   logic          accept;
   logic [3:0]    code;
   logic          store_wr;
   logic [CW-1:0] half;
   logic [3:0]    nib;

   smsahe_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .stat  (stat)
   );

   assign req_if.ready = stat.ctrl.take;
   assign accept       = req_if.valid && req_if.ready;
   assign code         = smsahe_pkg::char_code(req_if.number_char);
   assign store_wr     = accept && req_if.has_char && (raw_ff < CW'(MAX_CHARS))
                         && (code != smsahe_pkg::CODE_NONE);
   assign rd_addr      = idx_ff + AW'(stat.ctrl.rd_hi);
   assign half         = CW'(({1'b0, kept_ff} + (CW + 1)'(1)) >> 1);

   // The last flag is only tested in the idle step, where the request is always ready.
   always_comb begin
      flags.last_in  = req_if.valid && req_if.is_last;
      flags.ovf      = raw_ff >= CW'(MAX_CHARS);
      flags.rem_zero = rem_ff == CW'(0);
      flags.rem_one  = rem_ff == CW'(1);
      flags.rem_two  = rem_ff == CW'(2);
      flags.out_free = !rsp_valid_ff || rsp_if.ready;
   end

   always_comb begin
      case (stat.ctrl.src)
         smsahe_pkg::SRC_LEN_HI: nib = len_ff[7:4];
         smsahe_pkg::SRC_LEN_LO: nib = len_ff[3:0];
         smsahe_pkg::SRC_TOA_HI: nib = toa_ff[7:4];
         smsahe_pkg::SRC_TOA_LO: nib = toa_ff[3:0];
         smsahe_pkg::SRC_MEM:    nib = rd_data_ff;
         default:                nib = 4'hf;
      endcase
   end

   always_comb begin
      kept_in      = kept_ff;
      raw_in       = raw_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      toa_in       = toa_ff;
      rsp_valid_in = rsp_valid_ff;
      hex_in       = hex_ff;
      ovf_in       = ovf_ff;
      end_in       = end_ff;

      if (accept && req_if.has_char && (raw_ff < CW'(MAX_CHARS))) begin
         raw_in = raw_ff + CW'(1);
         if (store_wr) begin
            kept_in = kept_ff + CW'(1);
         end
      end
      if (accept && req_if.is_last) begin
         toa_in = smsahe_pkg::toa_octet(req_if.type_of_number, req_if.numbering_plan);
      end
      if (stat.go && stat.ctrl.start) begin
         len_in  = 8'(half) + 8'd1;
         rem_in  = kept_ff;
         idx_in  = '0;
         kept_in = '0;
         raw_in  = '0;
      end
      if (stat.go && stat.ctrl.adv) begin
         rem_in = rem_ff - CW'(2);
         idx_in = idx_ff + AW'(2);
      end

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (stat.go && stat.ctrl.emit) begin
         rsp_valid_in = 1'b1;
         end_in       = stat.end_run;
         if (stat.ctrl.src == smsahe_pkg::SRC_ERR) begin
            hex_in = 8'h00;
            ovf_in = 1'b1;
         end else begin
            hex_in = smsahe_pkg::hex_ascii(nib);
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff      <= '0;
         raw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kept_ff      <= kept_in;
         raw_ff       <= raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff <= rem_in;
      idx_ff <= idx_in;
      len_ff <= len_in;
      toa_ff <= toa_in;
      hex_ff <= hex_in;
      ovf_ff <= ovf_in;
      end_ff <= end_in;
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[kept_ff[AW-1:0]] <= code;
      end
      if (stat.go && stat.ctrl.rd) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.hex_char   = hex_ff;
   assign rsp_if.overflow   = ovf_ff;
   assign rsp_if.end_of_run = end_ff;

endmodule

// File: dv/address_encoding_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the hex-encoded SMS address and compares every response transaction.
module address_encoding_checker #(
   parameter int MAX_CHARS = 32
) (
   input  logic  clock,
   input  logic  reset,
   smsahe_req_if req_mon,
   smsahe_rsp_if rsp_mon,
   output int    mismatch_count,
   output int    pending_results
);

   typedef struct packed {
      logic [7:0] hex_char;
      logic       overflow;
      logic       end_of_run;
   } hex_result_type;

   hex_result_type expected_hex[$];
   logic [3:0]     digits[MAX_CHARS];
   int             kept_digits;
   int             raw_chars;

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      if (c >= smsahe_pkg::ASCII_ZERO && c <= smsahe_pkg::ASCII_NINE) begin
         return 4'(c - smsahe_pkg::ASCII_ZERO);
      end
      case (c)
         smsahe_pkg::ASCII_STAR: return smsahe_pkg::CODE_STAR;
         smsahe_pkg::ASCII_HASH: return smsahe_pkg::CODE_HASH;
         smsahe_pkg::ASCII_A:    return smsahe_pkg::CODE_A;
         smsahe_pkg::ASCII_B:    return smsahe_pkg::CODE_B;
         smsahe_pkg::ASCII_C:    return smsahe_pkg::CODE_C;
         default:                return smsahe_pkg::CODE_NONE;
      endcase
   endfunction

   function automatic logic [7:0] ascii_nibble(input logic [3:0] n);
      return (n < 4'd10) ? smsahe_pkg::ASCII_ZERO + 8'(n)
                         : smsahe_pkg::ASCII_A + 8'(n - 4'd10);
   endfunction

   function automatic logic [7:0] address_type(input logic [2:0] ton, input logic [3:0] npi);
      logic [2:0] t;
      logic [3:0] p;
      t = (ton > smsahe_pkg::TON_MAX) ? 3'd0 : ton;
      case (npi) inside
         smsahe_pkg::NPI_ISDN, smsahe_pkg::NPI_DATA, smsahe_pkg::NPI_TELEX,
         smsahe_pkg::NPI_NATIONAL, smsahe_pkg::NPI_PRIVATE: p = npi;
         default: p = 4'd0;
      endcase
      return 8'h80 | {1'b0, t, p};
   endfunction

   function automatic void push_octet(input logic [7:0] v);
      expected_hex.push_back('{ascii_nibble(v[7:4]), 1'b0, 1'b0});
      expected_hex.push_back('{ascii_nibble(v[3:0]), 1'b0, 1'b0});
   endfunction

   function automatic void encode_address(input logic [2:0] ton, input logic [3:0] npi);
      int             pairs;
      hex_result_type tail;
      if (raw_chars >= MAX_CHARS) begin
         expected_hex.push_back('{8'h00, 1'b1, 1'b1});
      end else begin
         pairs = kept_digits / 2;
         push_octet(8'(1 + pairs + kept_digits % 2));
         push_octet(address_type(ton, npi));
         for (int i = 0; i < pairs; i++) begin
            push_octet({digits[2 * i + 1], digits[2 * i]});
         end
         if (kept_digits % 2 == 1) begin
            push_octet({4'hf, digits[kept_digits - 1]});
         end
         tail = expected_hex.pop_back();
         tail.end_of_run = 1'b1;
         expected_hex.push_back(tail);
      end
      kept_digits = 0;
      raw_chars = 0;
   endfunction

   task automatic report_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : monitor
      hex_result_type want;
      logic [3:0]     code;
      if (reset) begin
         kept_digits = 0;
         raw_chars = 0;
         mismatch_count = 0;
         expected_hex.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_hex.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %h/%b/%b", $time,
                        rsp_mon.hex_char, rsp_mon.overflow, rsp_mon.end_of_run);
               mismatch_count++;
            end else begin
               want = expected_hex.pop_front();
               if (rsp_mon.hex_char !== want.hex_char) begin
                  report_field("hex_char", want.hex_char, rsp_mon.hex_char);
               end
               if (rsp_mon.overflow !== want.overflow) begin
                  report_field("overflow", 8'(want.overflow), 8'(rsp_mon.overflow));
               end
               if (rsp_mon.end_of_run !== want.end_of_run) begin
                  report_field("end_of_run", 8'(want.end_of_run), 8'(rsp_mon.end_of_run));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.has_char) begin
               code = digit_value(req_mon.number_char);
               if (raw_chars < MAX_CHARS) begin
                  if (code != smsahe_pkg::CODE_NONE && kept_digits < MAX_CHARS) begin
                     digits[kept_digits] = code;
                     kept_digits++;
                  end
                  raw_chars++;
               end
            end
            if (req_mon.is_last) begin
               encode_address(req_mon.type_of_number, req_mon.numbering_plan);
            end
         end
      end
      pending_results = expected_hex.size();
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the SMS address hex encoder testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;

   localparam int MAX_CHARS       = 32;
   localparam int ITEM_TARGET     = 320;
   localparam int IDLE_LIMIT      = 3000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT     = 100;
   localparam int DRAIN_CYCLES    = 40;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_results;
   int   items_sent;
   int   rsp_taken;
   int   idle_cycles = 0;
   bit   sender_burst;

   smsahe_req_if req_ch ();
   smsahe_rsp_if rsp_ch ();

   sms_address_hex_encoder #(.MAX_CHARS(MAX_CHARS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   address_encoding_checker #(.MAX_CHARS(MAX_CHARS)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .mismatch_count  (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] random_kept_char();
      int r;
      r = $urandom_range(0, 14);
      case (r)
         10: return smsahe_pkg::ASCII_STAR;
         11: return smsahe_pkg::ASCII_HASH;
         12: return smsahe_pkg::ASCII_A;
         13: return smsahe_pkg::ASCII_B;
         14: return smsahe_pkg::ASCII_C;
         default: return smsahe_pkg::ASCII_ZERO + 8'(r);
      endcase
   endfunction

   task automatic send_char(input logic has, input logic [7:0] ch, input logic last,
                            input logic [2:0] ton, input logic [3:0] npi);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid          <= 1'b0;
         req_ch.has_char       <= 1'($urandom);
         req_ch.number_char    <= 8'($urandom);
         req_ch.is_last        <= 1'($urandom);
         req_ch.type_of_number <= 3'($urandom);
         req_ch.numbering_plan <= 4'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.has_char       <= has;
      req_ch.number_char    <= ch;
      req_ch.is_last        <= last;
      req_ch.type_of_number <= ton;
      req_ch.numbering_plan <= npi;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (has || last) items_sent++;
   endtask

   task automatic drain_requests();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int         len;
      int         numbers;
      logic       has;
      logic [7:0] ch;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.has_char       = 1'b0;
      req_ch.number_char    = 8'h00;
      req_ch.is_last        = 1'b0;
      req_ch.type_of_number = 3'd0;
      req_ch.numbering_plan = 4'd0;
      sender_burst          = 1'b0;
      items_sent            = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_char(1'b0, 8'hff, 1'b1, 3'd0, 4'd0);
      send_char(1'b1, smsahe_pkg::ASCII_ZERO, 1'b1, 3'd7, 4'd15);
      send_char(1'b1, smsahe_pkg::ASCII_NINE, 1'b0, 3'd7, 4'd15);
      send_char(1'b1, smsahe_pkg::ASCII_STAR, 1'b0, 3'd0, 4'd0);
      send_char(1'b1, smsahe_pkg::ASCII_HASH, 1'b0, 3'd5, 4'd7);
      send_char(1'b1, smsahe_pkg::ASCII_A, 1'b0, 3'd2, 4'd10);
      send_char(1'b1, smsahe_pkg::ASCII_B, 1'b0, 3'd6, 4'd2);
      send_char(1'b1, smsahe_pkg::ASCII_C, 1'b0, 3'd1, 4'd5);
      send_char(1'b1, 8'h00, 1'b0, 3'd3, 4'd6);
      send_char(1'b1, 8'h2f, 1'b0, 3'd4, 4'd11);
      send_char(1'b1, 8'h3a, 1'b0, 3'd0, 4'd12);
      send_char(1'b1, 8'h41, 1'b0, 3'd7, 4'd13);
      send_char(1'b1, 8'h64, 1'b0, 3'd5, 4'd14);
      send_char(1'b1, 8'hff, 1'b0, 3'd2, 4'd0);
      send_char(1'b1, smsahe_pkg::ASCII_ZERO + 8'd1, 1'b1, 3'd4, smsahe_pkg::NPI_ISDN);
      send_char(1'b1, smsahe_pkg::ASCII_ZERO + 8'd5, 1'b0, 3'd7, 4'd15);
      send_char(1'b0, smsahe_pkg::ASCII_ZERO + 8'd6, 1'b0, 3'd0, 4'd0);
      send_char(1'b0, 8'h00, 1'b1, 3'd1, smsahe_pkg::NPI_DATA);
      send_char(1'b1, smsahe_pkg::ASCII_A, 1'b0, 3'd0, 4'd0);
      send_char(1'b1, smsahe_pkg::ASCII_ZERO + 8'd2, 1'b1, 3'd2, smsahe_pkg::NPI_TELEX);
      send_char(1'b1, smsahe_pkg::ASCII_ZERO + 8'd3, 1'b1, 3'd3, smsahe_pkg::NPI_NATIONAL);
      send_char(1'b1, 8'h64, 1'b1, 3'd5, smsahe_pkg::NPI_PRIVATE);
      send_char(1'b1, smsahe_pkg::ASCII_ZERO + 8'd7, 1'b1, 3'd6, 4'd2);
      drain_requests();

      numbers = 0;
      while (items_sent < ITEM_TARGET) begin
         if (numbers == 0) begin
            len = MAX_CHARS - 1;
         end else if (numbers == 1) begin
            len = MAX_CHARS + 1;
         end else if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(MAX_CHARS - 4, MAX_CHARS + 4);
         end else begin
            len = $urandom_range(1, 12);
         end
         if (numbers == 15) drain_requests();
         sender_burst = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) begin
            has = (numbers < 2) || ($urandom_range(0, 15) != 0);
            ch = (numbers < 2 || $urandom_range(0, 6) != 0) ? random_kept_char()
                                                             : 8'($urandom);
            send_char(has, ch, i == len - 1, 3'($urandom), 4'($urandom));
         end
         numbers++;
      end

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : receiver
      int gap;
      bit quiet;
      rsp_ch.ready = 1'b0;
      rsp_taken    = 0;
      quiet        = 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_taken % 24 == 0) quiet = ($urandom_range(0, 3) == 0);
         gap = quiet ? 0 : $urandom_range(0, 11);
         if (rsp_taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         rsp_taken++;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: filelist.f
hw/rtl/smsahe_pkg.sv
hw/rtl/smsahe_if.sv
hw/rtl/smsahe_seq.sv
hw/rtl/sms_address_hex_encoder.sv
dv/address_encoding_checker.sv
dv/testbench.sv
